@@ rtl/ghbp_pkg.sv @@
// Shared types, constants and helpers for the global history branch predictor.
// Depends on nothing; ghbp_hist, ghbp_pht and the top level import it.
package ghbp_pkg;

    // Table geometry and thread count.
    localparam int HISTORY_BITS = 12;
    localparam int COUNTER_BITS = 2;
    localparam int THREADS      = 4;

    // Fixed widths of the beat fields.
    localparam int OP_W     = 2;
    localparam int THREAD_W = 2;
    localparam int SNAP_W   = 12;

    // Derived sizes.
    localparam int TIDX_W    = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int TSEL_W    = (TIDX_W > THREAD_W) ? TIDX_W : THREAD_W;
    localparam int PHT_DEPTH = 1 << HISTORY_BITS;

    // Opcodes.
    localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd0;
    localparam logic [OP_W-1:0] OP_SPEC    = 2'd1;
    localparam logic [OP_W-1:0] OP_SQUASH  = 2'd2;
    localparam logic [OP_W-1:0] OP_RESOLVE = 2'd3;

    typedef logic [HISTORY_BITS-1:0] hist_t;
    typedef logic [COUNTER_BITS-1:0] ctr_t;
    typedef logic [SNAP_W-1:0]       snap_t;

    localparam ctr_t CTR_MAX = '1;

    // Request from the front stage to the pattern table.
    typedef struct packed {
        logic  rd;
        logic  train;
        logic  taken;
        hist_t idx;
    } pht_req_t;

    // History update carried by an accepted beat.
    typedef struct packed {
        logic            en;
        logic [OP_W-1:0] opcode;
        logic            taken;
        logic            squashed;
        hist_t           saved;
    } hist_upd_t;

    // One result beat.
    typedef struct packed {
        logic  pred;
        snap_t snap;
    } result_t;

    // Shift an outcome into a history, the oldest bit drops out.
    function automatic hist_t shift_in(hist_t hist, logic bit_in);
        hist_t res;
        res = {hist[HISTORY_BITS-2:0], bit_in};
        return res;
    endfunction

endpackage

@@ rtl/ghbp_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module ghbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; a read of the address being written returns old data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/ghbp_hist.sv @@
// Per-thread global history registers with their update logic.
// Depends on ghbp_pkg.
module ghbp_hist
    import ghbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [THREAD_W-1:0] thread,
    input  hist_upd_t           upd,
    output hist_t               cur_hist,
    output logic                thread_ok
);

    hist_t             hist_reg [THREADS];
    hist_t             hist_next;
    logic [TSEL_W-1:0] thread_ext;
    logic [TIDX_W-1:0] tidx;

    // Thread decode; numbers beyond the register file read as zero.
    assign thread_ext = TSEL_W'(thread);
    assign tidx       = thread_ext[TIDX_W-1:0];
    assign thread_ok  = (32'(thread) < 32'(THREADS));
    assign cur_hist   = thread_ok ? hist_reg[tidx] : '0;

    // New history for the opcode of the beat.
    always_comb
    begin
        case (upd.opcode)
            OP_SPEC:    hist_next = shift_in(cur_hist, upd.taken);
            OP_SQUASH:  hist_next = upd.saved;
            OP_RESOLVE: hist_next = upd.squashed ? shift_in(upd.saved, upd.taken) : cur_hist;
            default:    hist_next = cur_hist;
        endcase
    end

    // History register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < THREADS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (upd.en && thread_ok)
        begin
            hist_reg[tidx] <= hist_next;
        end
    end

endmodule

@@ rtl/ghbp_pht.sv @@
// Pattern history table: counter RAM with read-modify-write, write forwarding
// and the clearing pass after reset. Depends on ghbp_pkg and ghbp_ram.
module ghbp_pht
    import ghbp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pht_req_t req,
    output logic     busy,
    output logic     pred
);

    logic  clearing_reg;
    hist_t clr_addr_reg;
    logic  s1_train_reg;
    logic  s1_taken_reg;
    hist_t s1_idx_reg;
    logic  fwd_valid_reg;
    hist_t fwd_addr_reg;
    ctr_t  fwd_data_reg;

    ctr_t  rd_data;
    ctr_t  ctr_cur;
    ctr_t  ctr_new;
    logic  wr_en;
    hist_t wr_addr;
    ctr_t  wr_data;

    assign busy = clearing_reg;

    // Counter read in the previous cycle, patched with the write that shared its cycle.
    assign ctr_cur = (fwd_valid_reg && (fwd_addr_reg == s1_idx_reg)) ? fwd_data_reg : rd_data;
    assign pred    = ctr_cur[COUNTER_BITS-1];

    // Saturating increment or decrement.
    always_comb
    begin
        if (s1_taken_reg)
        begin
            ctr_new = (ctr_cur == CTR_MAX) ? ctr_cur : ctr_cur + ctr_t'(1);
        end
        else
        begin
            ctr_new = (ctr_cur == '0) ? ctr_cur : ctr_cur - ctr_t'(1);
        end
    end

    // Write port is shared by the clearing pass and training.
    assign wr_en   = clearing_reg || s1_train_reg;
    assign wr_addr = clearing_reg ? clr_addr_reg : s1_idx_reg;
    assign wr_data = clearing_reg ? '0 : ctr_new;

    ghbp_ram #(
        .WIDTH (COUNTER_BITS),
        .DEPTH (PHT_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (req.rd),
        .rd_addr (req.idx),
        .rd_data (rd_data)
    );

    // Clearing pass, one entry per cycle after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + hist_t'(1);
            if (clr_addr_reg == '1)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Read stage control and forwarding of the last write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_train_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s1_train_reg  <= req.rd && req.train;
            fwd_valid_reg <= wr_en;
        end
    end

    // Read stage payload.
    always_ff @(posedge clk)
    begin
        s1_taken_reg <= req.taken;
        if (req.rd)
        begin
            s1_idx_reg <= req.idx;
        end
        fwd_addr_reg <= wr_addr;
        fwd_data_reg <= wr_data;
    end

    // No training write may collide with the clearing pass.
    a_no_train_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) s1_train_reg |-> !clearing_reg
    ) else $error("training write during clearing pass");

endmodule

@@ rtl/global_history_branch_predictor_unit.sv @@
// Top level of the global history branch predictor (GAg).
// Depends on ghbp_pkg, ghbp_hist, ghbp_pht and ghbp_ram.
//
// Usage:
//   Input channel: in_valid / in_stall with opcode, thread, taken, uncond,
//   squashed and saved_history. A beat is taken at a rising edge with
//   in_valid high and in_stall low.
//   Output channel: out_valid / out_stall with prediction and
//   history_snapshot; exactly one result beat per input beat, in order.
//   Path: an accepted beat is registered in the read stage together with its
//   counter RAM read, then written into the output queue, from which it
//   can leave once out_valid is high and out_stall is low.
//   Throughput: one beat per cycle while in_stall is low; the counter RAM takes
//   one read and one write each cycle, and a training write is forwarded to a
//   read of the same entry issued in the same cycle.
//   Reset: histories clear at once; the counter table is swept to zero, one
//   entry per cycle over all 2^HISTORY_BITS = 4096 entries, during which
//   in_stall stays high.
//   Receiver stall: results wait in a two-entry output queue; in_stall rises
//   when the queue and the read stage together hold two beats that cannot
//   drain.
module global_history_branch_predictor_unit
    import ghbp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [OP_W-1:0]     opcode,
    input  logic [THREAD_W-1:0] thread,
    input  logic                taken,
    input  logic                uncond,
    input  logic                squashed,
    input  logic [SNAP_W-1:0]   saved_history,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                prediction,
    output logic [SNAP_W-1:0]   history_snapshot
);

    logic      accept;
    logic      pop;
    logic      push;
    logic      thread_ok;
    hist_t     cur_hist;
    hist_upd_t hist_upd;
    pht_req_t  pht_req;
    logic      pht_busy;
    logic      pht_pred;
    logic      is_train;
    logic [2:0] occ_after;

    logic      s1_valid_reg;
    logic      s1_lookup_reg;
    logic      s1_pred_reg;
    snap_t     s1_snap_reg;

    result_t    q_reg [2];
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       wr_ptr;
    result_t    push_data;

    // Handshakes.
    assign pop       = out_valid && !out_stall;
    assign occ_after = 3'(s1_valid_reg) + 3'(count_reg) - 3'(pop);
    assign in_stall  = pht_busy || (occ_after > 3'd1);
    assign accept    = in_valid && !in_stall;

    // History registers.
    assign hist_upd.en       = accept;
    assign hist_upd.opcode   = opcode;
    assign hist_upd.taken    = taken;
    assign hist_upd.squashed = squashed;
    assign hist_upd.saved    = hist_t'(saved_history);

    ghbp_hist u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .thread    (thread),
        .upd       (hist_upd),
        .cur_hist  (cur_hist),
        .thread_ok (thread_ok)
    );

    // Counter table requests: lookups read at the history, training at the snapshot.
    assign is_train      = (opcode == OP_RESOLVE) && !squashed;
    assign pht_req.rd    = accept && thread_ok && ((opcode == OP_LOOKUP) || is_train);
    assign pht_req.train = is_train;
    assign pht_req.taken = taken;
    assign pht_req.idx   = (opcode == OP_LOOKUP) ? cur_hist : hist_t'(saved_history);

    ghbp_pht u_pht (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (pht_req),
        .busy  (pht_busy),
        .pred  (pht_pred)
    );

    // Read stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    // Read stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_lookup_reg <= thread_ok && (opcode == OP_LOOKUP);
            s1_pred_reg   <= thread_ok && (opcode == OP_SPEC) && uncond;
            s1_snap_reg   <= thread_ok ? SNAP_W'(cur_hist) : '0;
        end
    end

    // Result of the read stage goes into the output queue.
    assign push           = s1_valid_reg;
    assign push_data.pred = s1_lookup_reg ? pht_pred : s1_pred_reg;
    assign push_data.snap = s1_snap_reg;
    assign wr_ptr         = rd_ptr_reg ^ count_reg[0];

    // Output queue control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    // Output queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr] <= push_data;
        end
    end

    assign out_valid        = (count_reg != 2'd0);
    assign prediction       = q_reg[rd_ptr_reg].pred;
    assign history_snapshot = q_reg[rd_ptr_reg].snap;

    // The queue never holds more than two beats.
    a_queue_bound: assert property (
        @(posedge clk) disable iff (!rst_n) count_reg != 2'd3
    ) else $error("output queue overflow");

    // A beat in the read stage always finds room in the queue.
    a_room_for_push: assert property (
        @(posedge clk) disable iff (!rst_n) s1_valid_reg |-> (count_reg != 2'd2 || pop)
    ) else $error("read stage result has no room");

    // An accepted beat reaches the read stage in the next cycle.
    a_accept_to_s1: assert property (
        @(posedge clk) disable iff (!rst_n) accept |=> s1_valid_reg
    ) else $error("accepted beat lost before read stage");

endmodule
